>>> rtl/hoa_pkg.sv
`timescale 1ns / 1ps
package hoa_pkg;
	localparam int RECORD_SLOTS = 32;
	localparam int INDEX_SLOTS = 64;	// power of two: bucket wrap is a mask
	localparam int KEY_BYTES = 8;
	localparam int IX_W = $clog2(INDEX_SLOTS);
	localparam int SL_W = $clog2(RECORD_SLOTS);
	localparam int CNT_W = $clog2(RECORD_SLOTS + 1);
	localparam int HS_STEPS = KEY_BYTES + 2;
	localparam int HS_W = $clog2(HS_STEPS);
	localparam int CFG_IDX_W = 1;

	localparam logic [31:0] FNV_BASIS = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME = 32'd16777619;
	localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

	localparam logic [CFG_IDX_W-1:0] CFG_MONITORING = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLLECTION = 1'b1;
	localparam logic ACT_RECORD = 1'b0;
	localparam logic ACT_FLUSH = 1'b1;
	localparam logic KIND_RECORD = 1'b0;
	localparam logic KIND_MARKER = 1'b1;

	typedef struct packed {
		logic action;
		logic [63:0] identity_key;
		logic [1:0] shader_stage;
		logic [1:0] pixel_path;
		logic [63:0] frame_number;
		logic [31:0] scope_tag;
		logic last_in_draw;
	} item_t;

	typedef struct packed {
		logic result_kind;
		logic [63:0] record_key;
		logic [1:0] record_stage;
		logic [1:0] record_route;
		logic [63:0] first_seen;
		logic [63:0] last_seen;
		logic [31:0] draws;
		logic [31:0] uber_draws;
		logic [31:0] other_draws;
		logic [63:0] marker_frame;
		logic last;
	} result_t;

	// classified command from front to back
	typedef struct packed {
		logic flush;
		logic [63:0] key;
		logic [1:0] stage;
		logic [1:0] route;
		logic [63:0] frame;
		logic [31:0] scope;
		logic [IX_W-1:0] home;
	} cmd_t;

	typedef struct packed {
		logic [63:0] key;
		logic [1:0] stage;
		logic [1:0] route;
		logic [63:0] first;
		logic [63:0] last;
		logic [31:0] draws;
		logic [31:0] uber;
		logic [31:0] other;
	} slot_t;

	// all ones when the key is the full 64 bits (shift wraps to zero)
	function automatic logic [63:0] key_mask();
		key_mask = (64'd1 << (8 * KEY_BYTES)) - 64'd1;
	endfunction

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		sat_inc = (v == CNT_MAX) ? v : v + 32'd1;
	endfunction
endpackage

>>> rtl/hoa_front.sv
`timescale 1ns / 1ps
module hoa_front (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input hoa_pkg::item_t item,
	input logic monitoring_on,
	output logic cmd_valid,
	output hoa_pkg::cmd_t cmd,
	input logic cmd_pop
);
	import hoa_pkg::*;

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_HASH = 3'b010,
		F_PUSH = 3'b100
	} fst_t;

	fst_t st_q;
	cmd_t c_q;
	logic [31:0] h_q;
	logic [HS_W-1:0] hs_q;
	cmd_t qm_q [2];
	logic qw_q, qr_q;
	logic [1:0] qc_q;

	logic take, qfull, qpush, qpop;
	logic [1:0] route;
	logic [63:0] ksh;
	logic [7:0] hd;
	logic [31:0] h_nx;
	cmd_t qin;

	assign full = (st_q != F_IDLE);
	// record items with monitoring off cause nothing and are dropped here
	assign take = push && !full && (item.action == ACT_FLUSH || monitoring_on);

	always_comb begin
		case (item.shader_stage)
			2'd0: route = 2'd0;
			2'd1: route = item.pixel_path;
			default: route = 2'd1;
		endcase
	end

	assign ksh = c_q.key >> {hs_q, 3'b000};
	always_comb begin
		if (hs_q < HS_W'(KEY_BYTES)) hd = ksh[7:0];
		else if (hs_q == HS_W'(KEY_BYTES)) hd = {6'd0, c_q.stage};
		else hd = {6'd0, c_q.route};
	end
	assign h_nx = (h_q ^ {24'd0, hd}) * FNV_PRIME;

	assign qfull = (qc_q == 2'd2);
	assign qpush = (st_q == F_PUSH) && !qfull;
	assign qpop = cmd_pop && cmd_valid;

	always_comb begin
		qin = c_q;
		qin.home = h_q[IX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= F_IDLE;
			hs_q <= '0;
		end else begin
			case (st_q)
				F_IDLE: begin
					if (take) begin
						hs_q <= '0;
						st_q <= (item.action == ACT_FLUSH) ? F_PUSH : F_HASH;
					end
				end
				F_HASH: begin
					hs_q <= hs_q + HS_W'(1);
					if (hs_q == HS_W'(HS_STEPS - 1)) st_q <= F_PUSH;
				end
				F_PUSH: begin
					if (!qfull) st_q <= F_IDLE;
				end
				default: st_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == F_IDLE && take) begin
			c_q.flush <= item.action;
			c_q.key <= item.identity_key & key_mask();
			c_q.stage <= item.shader_stage;
			c_q.route <= route;
			c_q.frame <= item.frame_number;
			c_q.scope <= item.scope_tag;
			c_q.home <= '0;
			h_q <= FNV_BASIS;
		end else if (st_q == F_HASH) begin
			h_q <= h_nx;
		end
		if (qpush) qm_q[qw_q] <= qin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qw_q <= 1'b0;
			qr_q <= 1'b0;
			qc_q <= '0;
		end else begin
			if (qpush) qw_q <= ~qw_q;
			if (qpop) qr_q <= ~qr_q;
			qc_q <= qc_q + {1'b0, qpush} - {1'b0, qpop};
		end
	end

	assign cmd_valid = (qc_q != 2'd0);
	assign cmd = qm_q[qr_q];
endmodule

>>> rtl/hoa_back.sv
`timescale 1ns / 1ps
module hoa_back (
	input logic clk,
	input logic arst_n,
	input logic collection_on,
	input logic cmd_valid,
	input hoa_pkg::cmd_t cmd,
	output logic cmd_pop,
	output logic empty,
	input logic pop,
	output hoa_pkg::result_t result
);
	import hoa_pkg::*;

	localparam int ODEPTH = 4;

	typedef enum logic [9:0] {
		B_IDLE   = 10'b0000000001,
		B_PUB_RD = 10'b0000000010,
		B_PUB_WR = 10'b0000000100,
		B_MARK   = 10'b0000001000,
		B_COLL   = 10'b0000010000,
		B_PRB_RD = 10'b0000100000,
		B_PRB_IX = 10'b0001000000,
		B_PRB_SL = 10'b0010000000,
		B_MISS   = 10'b0100000000,
		B_INS    = 10'b1000000000
	} bst_t;

	bst_t st_q, ret_q;
	cmd_t c_q;
	logic [31:0] scope_q;
	logic [CNT_W-1:0] used_q;
	logic [SL_W-1:0] pi_q;
	logic [IX_W-1:0] b_q, pc_q, ins_q;
	logic nofree_q;

	logic [CNT_W-1:0] idx_mem [INDEX_SLOTS];
	logic [CNT_W-1:0] idx_rd_q;
	logic [INDEX_SLOTS-1:0] vld_q;
	slot_t slot_mem [RECORD_SLOTS];
	slot_t sl_rd_q;

	result_t om_q [ODEPTH];
	logic [1:0] ow_q, or_q;
	logic [2:0] oc_q;
	logic ofull, opush, opop;
	result_t od;

	logic [SL_W-1:0] sl_ra, sl_wa;
	logic sl_we, match, pub_end, idx_we;
	slot_t sl_wd;

	assign ofull = (oc_q == 3'(ODEPTH));
	assign opop = pop && !empty;
	assign cmd_pop = (st_q == B_IDLE) && cmd_valid;
	assign match = (sl_rd_q.key == c_q.key) && (sl_rd_q.stage == c_q.stage) &&
		(sl_rd_q.route == c_q.route);
	assign pub_end = ({1'b0, pi_q} == used_q - CNT_W'(1));
	assign idx_we = (st_q == B_INS);

	always_comb begin
		case (st_q)
			B_PUB_RD, B_PUB_WR: sl_ra = pi_q;
			default: sl_ra = SL_W'(idx_rd_q - CNT_W'(1));
		endcase
	end

	// output beat and slot write
	always_comb begin
		od = '0;
		opush = 1'b0;
		sl_we = 1'b0;
		sl_wa = SL_W'(idx_rd_q - CNT_W'(1));
		sl_wd = sl_rd_q;
		case (st_q)
			B_PUB_WR: begin
				opush = !ofull;
				od.result_kind = KIND_RECORD;
				od.record_key = sl_rd_q.key;
				od.record_stage = sl_rd_q.stage;
				od.record_route = sl_rd_q.route;
				od.first_seen = sl_rd_q.first;
				od.last_seen = sl_rd_q.last;
				od.draws = sl_rd_q.draws;
				od.uber_draws = sl_rd_q.uber;
				od.other_draws = sl_rd_q.other;
				od.last = pub_end && !c_q.flush;
			end
			B_MARK: begin
				opush = !ofull;
				od.result_kind = KIND_MARKER;
				od.marker_frame = c_q.frame;
				od.last = 1'b1;
			end
			B_PRB_SL: begin
				sl_we = match;
				sl_wd.last = c_q.frame;
				sl_wd.draws = sat_inc(sl_rd_q.draws);
				if (c_q.route == 2'd2) sl_wd.uber = sat_inc(sl_rd_q.uber);
				else sl_wd.other = sat_inc(sl_rd_q.other);
			end
			B_INS: begin
				sl_we = 1'b1;
				sl_wa = used_q[SL_W-1:0];
				sl_wd.key = c_q.key;
				sl_wd.stage = c_q.stage;
				sl_wd.route = c_q.route;
				sl_wd.first = c_q.frame;
				sl_wd.last = c_q.frame;
				sl_wd.draws = 32'd1;
				sl_wd.uber = {31'd0, c_q.route == 2'd2};
				sl_wd.other = {31'd0, c_q.route != 2'd2};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (sl_we) slot_mem[sl_wa] <= sl_wd;
		sl_rd_q <= slot_mem[sl_ra];
		if (idx_we) idx_mem[ins_q] <= used_q + CNT_W'(1);
		idx_rd_q <= idx_mem[b_q];
		if (cmd_pop) c_q <= cmd;
		if (opush) om_q[ow_q] <= od;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE;
			ret_q <= B_IDLE;
			scope_q <= '0;
			used_q <= '0;
			pi_q <= '0;
			b_q <= '0;
			pc_q <= '0;
			ins_q <= '0;
			nofree_q <= 1'b0;
			vld_q <= '0;
		end else begin
			case (st_q)
				B_IDLE: begin
					if (cmd_valid) begin
						pi_q <= '0;
						if (cmd.flush) begin
							ret_q <= B_MARK;
							st_q <= (used_q == '0) ? B_MARK : B_PUB_RD;
						end else if (cmd.scope != scope_q) begin
							scope_q <= cmd.scope;
							ret_q <= B_COLL;
							st_q <= (used_q == '0) ? B_COLL : B_PUB_RD;
						end else begin
							st_q <= B_COLL;
						end
					end
				end
				B_PUB_RD: st_q <= B_PUB_WR;
				B_PUB_WR: begin
					if (!ofull) begin
						if (pub_end) begin
							used_q <= '0;
							vld_q <= '0;
							st_q <= ret_q;
						end else begin
							pi_q <= pi_q + SL_W'(1);
							st_q <= B_PUB_RD;
						end
					end
				end
				B_MARK: begin
					if (!ofull) st_q <= B_IDLE;
				end
				B_COLL: begin
					b_q <= c_q.home;
					pc_q <= '0;
					nofree_q <= 1'b0;
					st_q <= collection_on ? B_PRB_RD : B_IDLE;
				end
				B_PRB_RD: st_q <= B_PRB_IX;
				B_PRB_IX: begin
					if (!vld_q[b_q]) begin
						ins_q <= b_q;
						st_q <= B_MISS;
					end else begin
						st_q <= B_PRB_SL;
					end
				end
				B_PRB_SL: begin
					if (match) begin
						st_q <= B_IDLE;
					end else if (pc_q == IX_W'(INDEX_SLOTS - 1)) begin
						nofree_q <= 1'b1;
						st_q <= B_MISS;
					end else begin
						b_q <= b_q + IX_W'(1);
						pc_q <= pc_q + IX_W'(1);
						st_q <= B_PRB_RD;
					end
				end
				B_MISS: begin
					if (nofree_q || used_q == CNT_W'(RECORD_SLOTS)) begin
						// batch or index table full: publish, then insert at the home bucket
						ins_q <= c_q.home;
						pi_q <= '0;
						ret_q <= B_INS;
						st_q <= B_PUB_RD;
					end else begin
						st_q <= B_INS;
					end
				end
				B_INS: begin
					vld_q[ins_q] <= 1'b1;
					used_q <= used_q + CNT_W'(1);
					st_q <= B_IDLE;
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ow_q <= '0;
			or_q <= '0;
			oc_q <= '0;
		end else begin
			if (opush) ow_q <= ow_q + 2'd1;
			if (opop) or_q <= or_q + 2'd1;
			oc_q <= oc_q + {2'd0, opush} - {2'd0, opop};
		end
	end

	assign empty = (oc_q == 3'd0);
	assign result = om_q[or_q];

`ifndef SYNTHESIS
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(RECORD_SLOTS))
		else $error("record count above capacity");
	a_ofifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		oc_q <= 3'(ODEPTH))
		else $error("result queue overflow");
	a_ins_room: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == B_INS |-> used_q < CNT_W'(RECORD_SLOTS) && !vld_q[ins_q])
		else $error("insert into full batch or taken bucket");
	a_pub_clears: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == B_PUB_WR && !ofull && pub_end |=> used_q == '0 && vld_q == '0)
		else $error("publish did not clear batch");
`endif
endmodule

>>> rtl/hashed_observation_aggregator.sv
`timescale 1ns / 1ps
// channel   dir  handshake          payload
// item      in   push / full        hoa_pkg::item_t, accepted on push && !full
// result    out  empty / pop        hoa_pkg::result_t, taken on pop && !empty
// cfg       in   cfg_we             cfg_idx selects register, cfg_data value
//
// front holds full while busy: KEY_BYTES + 2 fnv steps (none for a flush), one queue push
// back dispatches via B_IDLE and B_COLL, then probes each occupied bucket via B_PRB_RD,
// B_PRB_IX and B_PRB_SL; a hit updates in B_PRB_SL, an empty bucket goes via B_MISS to B_INS
// publish moves records one at a time via B_PUB_RD, B_PUB_WR into a 4-deep result queue
// a two-entry command queue lets the front hash while the back probes or publishes
// arst_n clears the index table valid bits, record count and scope at once
// a full result queue stalls the back, then the front as commands back up; full = front busy
module hashed_observation_aggregator (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input hoa_pkg::item_t item,
	output logic empty,
	input logic pop,
	output hoa_pkg::result_t result,
	input logic cfg_we,
	input logic [hoa_pkg::CFG_IDX_W-1:0] cfg_idx,
	input logic cfg_data
);
	import hoa_pkg::*;

	logic mon_q, col_q;
	logic cmd_valid, cmd_pop;
	cmd_t cmd;

	// config registers, written only while idle: a rule for the user, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mon_q <= 1'b0;
			col_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_MONITORING: mon_q <= cfg_data;
				CFG_COLLECTION: col_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// accept, route classification and hashing
	hoa_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.monitoring_on(mon_q),
		.cmd_valid(cmd_valid),
		.cmd(cmd),
		.cmd_pop(cmd_pop)
	);

	// probing, record update, batch publish and frame markers
	hoa_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.collection_on(col_q),
		.cmd_valid(cmd_valid),
		.cmd(cmd),
		.cmd_pop(cmd_pop),
		.empty(empty),
		.pop(pop),
		.result(result)
	);
endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import hoa_pkg::*;

	localparam int SETTLE_CYCLES = 2000;	// queued commands with long probes, with margin
	localparam int STALL_LIMIT = 20000;	// cycles with no beat on either side

	typedef struct {
		bit wr_cfg;	// go idle and write both registers first
		bit mon;
		bit col;
		bit typed;	// expected marker typed in, predictor only tracks state
		item_t it;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	item_t item;
	logic empty;
	logic pop;
	result_t result;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic cfg_data;

	hashed_observation_aggregator dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.empty(empty),
		.pop(pop),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// shadow of the aggregation table
	logic [6:0] bucket_map [INDEX_SLOTS];	// 0 empty, else record number + 1
	logic [63:0] rec_key [RECORD_SLOTS];
	logic [3:0] rec_sr [RECORD_SLOTS];
	logic [63:0] rec_first [RECORD_SLOTS];
	logic [63:0] rec_last [RECORD_SLOTS];
	logic [31:0] rec_draws [RECORD_SLOTS];
	logic [31:0] rec_uber [RECORD_SLOTS];
	logic [31:0] rec_other [RECORD_SLOTS];
	int records_held;
	logic [31:0] scope_gen;
	bit monitor_en;
	bit collect_en;

	result_t pending_results [$];
	int fail_count;
	int idle_cycles;
	bit no_idle;	// stretches where both sides run flat out

	function automatic logic [31:0] fnv_bucket(logic [63:0] k, logic [1:0] st, logic [1:0] rt);
		logic [31:0] h;
		h = FNV_BASIS;
		for (int i = 0; i < KEY_BYTES; i++)
			h = (h ^ {24'd0, k[8*i +: 8]}) * FNV_PRIME;
		h = (h ^ {30'd0, st}) * FNV_PRIME;
		h = (h ^ {30'd0, rt}) * FNV_PRIME;
		return h % INDEX_SLOTS;
	endfunction

	function automatic logic [31:0] bump(logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	// dump the batch as record beats and clear the index
	function automatic void drain_shadow(ref result_t q [$]);
		result_t r;
		for (int i = 0; i < records_held; i++) begin
			r = '0;
			r.result_kind = KIND_RECORD;
			r.record_key = rec_key[i];
			r.record_stage = rec_sr[i][3:2];
			r.record_route = rec_sr[i][1:0];
			r.first_seen = rec_first[i];
			r.last_seen = rec_last[i];
			r.draws = rec_draws[i];
			r.uber_draws = rec_uber[i];
			r.other_draws = rec_other[i];
			q.push_back(r);
		end
		records_held = 0;
		for (int b = 0; b < INDEX_SLOTS; b++)
			bucket_map[b] = '0;
	endfunction

	// expected beats caused by one accepted item
	function automatic void aggregate_observation(item_t x, ref result_t q [$]);
		result_t r;
		logic [63:0] k;
		logic [1:0] rt;
		logic [3:0] sr;
		int home, b, hit, hole, slot, n0;
		n0 = q.size();
		k = x.identity_key & ((KEY_BYTES >= 8) ? '1 : ((64'd1 << (8 * KEY_BYTES)) - 1));
		if (x.action == ACT_FLUSH) begin
			drain_shadow(q);
			r = '0;
			r.result_kind = KIND_MARKER;
			r.marker_frame = x.frame_number;
			r.last = 1'b1;
			q.push_back(r);
			return;
		end
		if (!monitor_en)
			return;
		if (x.scope_tag != scope_gen) begin
			drain_shadow(q);
			scope_gen = x.scope_tag;
		end
		if (collect_en) begin
			rt = (x.shader_stage == 2'd0) ? 2'd0 :
				(x.shader_stage == 2'd1) ? x.pixel_path : 2'd1;
			sr = {x.shader_stage, rt};
			home = fnv_bucket(k, x.shader_stage, rt);
			b = home;
			hit = -1;
			hole = -1;
			// linear probe until a match or an empty bucket
			for (int s = 0; s < INDEX_SLOTS; s++) begin
				if (bucket_map[b] == 0) begin
					hole = b;
					break;
				end
				slot = bucket_map[b] - 1;
				if (slot < RECORD_SLOTS && rec_sr[slot] == sr && rec_key[slot] == k) begin
					hit = slot;
					break;
				end
				b = (b + 1) % INDEX_SLOTS;
			end
			if (hit < 0) begin
				if (hole < 0 || records_held >= RECORD_SLOTS) begin
					drain_shadow(q);
					hole = home;
				end
				slot = records_held;
				records_held++;
				bucket_map[hole] = 7'(records_held);
				rec_key[slot] = k;
				rec_sr[slot] = sr;
				rec_first[slot] = x.frame_number;
				rec_draws[slot] = '0;
				rec_uber[slot] = '0;
				rec_other[slot] = '0;
			end else begin
				slot = hit;
			end
			rec_last[slot] = x.frame_number;
			rec_draws[slot] = bump(rec_draws[slot]);
			if (rt == 2'd2)
				rec_uber[slot] = bump(rec_uber[slot]);
			else
				rec_other[slot] = bump(rec_other[slot]);
		end
		if (q.size() > n0)
			q[q.size() - 1].last = 1'b1;
	endfunction

	// result side: random pop gaps, compare each beat to the oldest expectation
	initial begin
		result_t want;
		int w;
		pop <= 1'b0;
		forever begin
			w = no_idle ? 0 : $urandom_range(0, 9);
			if (w > 0) begin
				pop <= 1'b0;
				repeat (w) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty !== 1'b0);
			if (pending_results.size() == 0) begin
				$error("unexpected result beat kind=%0d key=%h", result.result_kind,
					result.record_key);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (result.result_kind !== want.result_kind) begin
					$error("result_kind: expected %0d, got %0d", want.result_kind,
						result.result_kind);
					fail_count++;
				end
				if (result.record_key !== want.record_key) begin
					$error("record_key: expected %h, got %h", want.record_key, result.record_key);
					fail_count++;
				end
				if (result.record_stage !== want.record_stage) begin
					$error("record_stage: expected %0d, got %0d", want.record_stage,
						result.record_stage);
					fail_count++;
				end
				if (result.record_route !== want.record_route) begin
					$error("record_route: expected %0d, got %0d", want.record_route,
						result.record_route);
					fail_count++;
				end
				if (result.first_seen !== want.first_seen) begin
					$error("first_seen: expected %h, got %h", want.first_seen, result.first_seen);
					fail_count++;
				end
				if (result.last_seen !== want.last_seen) begin
					$error("last_seen: expected %h, got %h", want.last_seen, result.last_seen);
					fail_count++;
				end
				if (result.draws !== want.draws) begin
					$error("draws: expected %0d, got %0d", want.draws, result.draws);
					fail_count++;
				end
				if (result.uber_draws !== want.uber_draws) begin
					$error("uber_draws: expected %0d, got %0d", want.uber_draws,
						result.uber_draws);
					fail_count++;
				end
				if (result.other_draws !== want.other_draws) begin
					$error("other_draws: expected %0d, got %0d", want.other_draws,
						result.other_draws);
					fail_count++;
				end
				if (result.marker_frame !== want.marker_frame) begin
					$error("marker_frame: expected %h, got %h", want.marker_frame,
						result.marker_frame);
					fail_count++;
				end
				if (result.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, result.last);
					fail_count++;
				end
			end
		end
	end

	// watchdog: any beat on either side resets the count
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	// one item beat: gap, then hold push until full drops
	task automatic send_item(item_t x, bit typed);
		result_t scratch [$];
		result_t r;
		int g;
		g = no_idle ? 0 : $urandom_range(0, 9);
		if (g > 0) begin
			push <= 1'b0;
			repeat (g) @(posedge clk);
		end
		push <= 1'b1;
		item <= x;
		do @(posedge clk); while (full !== 1'b0);
		if (typed) begin
			// empty batch flush: just the marker
			aggregate_observation(x, scratch);
			r = '0;
			r.result_kind = KIND_MARKER;
			r.marker_frame = x.frame_number;
			r.last = 1'b1;
			pending_results.push_back(r);
		end else begin
			aggregate_observation(x, pending_results);
		end
	endtask

	// wait for the block to go quiet, then write both registers
	task automatic set_regs(bit mon, bit col);
		push <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= CFG_MONITORING;
		cfg_data <= mon;
		@(posedge clk);
		cfg_idx <= CFG_COLLECTION;
		cfg_data <= col;
		@(posedge clk);
		cfg_we <= 1'b0;
		monitor_en = mon;
		collect_en = col;
	endtask

	function automatic item_t make_item(bit act, logic [63:0] k, logic [1:0] st,
		logic [1:0] pp, logic [63:0] fr, logic [31:0] sc, bit lst);
		item_t x;
		x.action = act;
		x.identity_key = k;
		x.shader_stage = st;
		x.pixel_path = pp;
		x.frame_number = fr;
		x.scope_tag = sc;
		x.last_in_draw = lst;
		return x;
	endfunction

	function automatic stim_row_t row(bit wr, bit mon, bit col, bit typed, item_t x);
		stim_row_t r;
		r.wr_cfg = wr;
		r.mon = mon;
		r.col = col;
		r.typed = typed;
		r.it = x;
		return r;
	endfunction

	stim_row_t directed [$];
	logic [63:0] key_pool [48];
	logic [31:0] scope_pool [4];

	// random phase: mostly draws from a small key pool so records repeat and fill
	task automatic random_phase(int count);
		item_t x;
		logic [63:0] frame;
		frame = {$urandom, $urandom};
		for (int n = 0; n < count; n++) begin
			if (n % 50 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 7) != 0)
				frame = frame + $urandom_range(0, 1);
			else
				frame = {$urandom, $urandom};
			x = make_item(ACT_RECORD,
				($urandom_range(0, 9) == 0) ? {$urandom, $urandom} :
					key_pool[$urandom_range(0, 47)],
				2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), frame,
				($urandom_range(0, 39) == 0) ? scope_pool[$urandom_range(0, 3)] : scope_gen,
				1'($urandom_range(0, 1)));
			if ($urandom_range(0, 24) == 0)
				x.action = ACT_FLUSH;
			send_item(x, 1'b0);
		end
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = 1'b0;
		no_idle = 1'b0;
		records_held = 0;
		scope_gen = '0;
		monitor_en = 1'b0;
		collect_en = 1'b0;
		for (int b = 0; b < INDEX_SLOTS; b++)
			bucket_map[b] = '0;
		for (int i = 0; i < 48; i++)
			key_pool[i] = {$urandom, $urandom};
		key_pool[0] = '0;
		key_pool[1] = '1;
		scope_pool[0] = '0;
		scope_pool[1] = '1;
		scope_pool[2] = $urandom;
		scope_pool[3] = 32'd1;

		// after reset: flush marker, ignored draw with monitoring off
		directed.push_back(row(1'b0, 1'b0, 1'b0, 1'b1, make_item(ACT_FLUSH, '1, 2'd3, 2'd3,
			64'd7, '1, 1'b1)));
		directed.push_back(row(1'b0, 1'b0, 1'b0, 1'b0, make_item(ACT_RECORD, 64'h11, 2'd1,
			2'd2, 64'd8, 32'd0, 1'b1)));
		// monitoring without collection: scope change taken, nothing recorded
		directed.push_back(row(1'b1, 1'b1, 1'b0, 1'b0, make_item(ACT_RECORD, 64'h22, 2'd2,
			2'd0, 64'd9, 32'd5, 1'b0)));
		directed.push_back(row(1'b0, 1'b1, 1'b0, 1'b1, make_item(ACT_FLUSH, '0, 2'd0, 2'd0,
			'0, 32'd0, 1'b0)));
		// full collection: every stage and pixel route, key extremes
		directed.push_back(row(1'b1, 1'b1, 1'b1, 1'b0, make_item(ACT_RECORD, '0, 2'd0, 2'd3,
			64'd10, 32'd5, 1'b1)));
		directed.push_back(row(1'b0, 1'b1, 1'b1, 1'b0, make_item(ACT_RECORD, '1, 2'd1, 2'd0,
			64'd10, 32'd5, 1'b0)));
		directed.push_back(row(1'b0, 1'b1, 1'b1, 1'b0, make_item(ACT_RECORD, '1, 2'd1, 2'd1,
			64'd11, 32'd5, 1'b1)));
		directed.push_back(row(1'b0, 1'b1, 1'b1, 1'b0, make_item(ACT_RECORD, '1, 2'd1, 2'd2,
			64'd11, 32'd5, 1'b0)));
		directed.push_back(row(1'b0, 1'b1, 1'b1, 1'b0, make_item(ACT_RECORD, '1, 2'd1, 2'd3,
			64'd12, 32'd5, 1'b1)));
		directed.push_back(row(1'b0, 1'b1, 1'b1, 1'b0, make_item(ACT_RECORD,
			64'h0123_4567_89AB_CDEF, 2'd2, 2'd2, '1, 32'd5, 1'b1)));
		directed.push_back(row(1'b0, 1'b1, 1'b1, 1'b0, make_item(ACT_RECORD,
			64'h0123_4567_89AB_CDEF, 2'd3, 2'd1, '1, 32'd5, 1'b0)));
		// repeats hit existing records
		directed.push_back(row(1'b0, 1'b1, 1'b1, 1'b0, make_item(ACT_RECORD, '1, 2'd1, 2'd2,
			64'd13, 32'd5, 1'b1)));
		directed.push_back(row(1'b0, 1'b1, 1'b1, 1'b0, make_item(ACT_RECORD, '0, 2'd0, 2'd1,
			64'd14, 32'd5, 1'b1)));
		// scope change publishes, then flush with frame extreme
		directed.push_back(row(1'b0, 1'b1, 1'b1, 1'b0, make_item(ACT_RECORD, 64'hFF, 2'd1,
			2'd2, 64'd15, '1, 1'b1)));
		directed.push_back(row(1'b0, 1'b1, 1'b1, 1'b0, make_item(ACT_FLUSH, 64'h5A, 2'd1,
			2'd1, '1, '0, 1'b1)));
		directed.push_back(row(1'b0, 1'b1, 1'b1, 1'b0, make_item(ACT_RECORD,
			64'h8000_0000_0000_0001, 2'd2, 2'd3, '0, '1, 1'b0)));
		// collection off with a scope change still publishes
		directed.push_back(row(1'b1, 1'b1, 1'b0, 1'b0, make_item(ACT_RECORD, 64'h33, 2'd0,
			2'd0, 64'd20, 32'd9, 1'b1)));
		directed.push_back(row(1'b1, 1'b0, 1'b1, 1'b0, make_item(ACT_RECORD, 64'h44, 2'd1,
			2'd2, 64'd21, 32'd3, 1'b1)));
		directed.push_back(row(1'b0, 1'b0, 1'b1, 1'b0, make_item(ACT_FLUSH, 64'h44, 2'd1,
			2'd2, 64'd22, 32'd3, 1'b0)));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].wr_cfg)
				set_regs(directed[i].mon, directed[i].col);
			send_item(directed[i].it, directed[i].typed);
		end

		set_regs(1'b1, 1'b1);
		random_phase(280);
		set_regs(1'b0, 1'b1);
		random_phase(30);
		set_regs(1'b1, 1'b0);
		random_phase(30);
		set_regs(1'b1, 1'b1);
		random_phase(80);

		push <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end
endmodule
